FILE: src/kcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker package
// Shared operation codes, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package kcc_pkg;

    typedef enum logic [1:0] {
        OP_ADD_KEY       = 2'd0,
        OP_RESET         = 2'd1,
        OP_CHECK_SECRET  = 2'd2,
        OP_CHECK_STARTED = 2'd3
    } t_op;

    localparam int PREAMBLE_LEN = 3;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_SECRET_KEYS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECRET_LENGTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_MS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_KEY_CODE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMPTY_KEY_CODE = 3'd4;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [3:0]  STOP_RESET    = 4'd1;

    typedef enum logic [1:0] {
        ANS_ZERO,
        ANS_FOUND,
        ANS_SECRET
    } t_ans_sel;

    typedef struct packed {
        logic     capture;
        logic     decide;
        logic     scan_start;
        logic     issue;
        logic     cmp_start;
        logic     load_out;
        t_ans_sel ans_sel;
    } t_cmd;

    typedef struct packed {
        t_op        op;
        logic       expired;
        logic       too_long;
        logic       found;
        logic [3:0] secret_length;
        logic       out_free;
    } t_stat;

endpackage

FILE: src/kcc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface kcc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  key;
    logic [31:0] now_ms;

    modport source (output valid, output operation, output key, output now_ms,
                    input ready);
    modport sink   (input valid, input operation, input key, input now_ms,
                    output ready);
endinterface

interface kcc_result_if;
    logic valid;
    logic ready;
    logic answer;
    logic timed_out;

    modport source (output valid, output answer, output timed_out, input ready);
    modport sink   (input valid, input answer, input timed_out, output ready);
endinterface

FILE: src/keypad_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker
// Key buffer with inactivity timeout, preamble search and secret compare.
// ----------------------------------------------------------------------------
// One item is taken at a time. Add key and reset items go from the decide
// state straight to the finish state; check started scans the key buffer,
// and check secret scans it and then compares the secret keys, unless a
// timeout or a too-long secret ends it early. The key buffer has a single
// read port: it is swept once for the preamble search and then read once
// per secret key. A result waits in an output register, so the next item
// can be taken while it does.
module keypad_code_checker
    import kcc_pkg::*;
#(
    parameter int KEY_BUFFER_DEPTH = 16,
    parameter int KEY_BITS         = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kcc_item_if.sink              i_item,
    kcc_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;
    logic  w_answer;
    logic  w_timed_out;

    assign i_item.ready       = w_in_ready;
    assign o_result.valid     = w_out_valid;
    assign o_result.answer    = w_answer;
    assign o_result.timed_out = w_timed_out;

    kcc_controller #(
        .KEY_BUFFER_DEPTH(KEY_BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    kcc_datapath #(
        .KEY_BUFFER_DEPTH(KEY_BUFFER_DEPTH),
        .KEY_BITS        (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_operation (i_item.operation),
        .i_key       (i_item.key),
        .i_now_ms    (i_item.now_ms),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_answer    (w_answer),
        .o_timed_out (w_timed_out)
    );

endmodule

FILE: src/kcc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker controller
// Sequences one item: timeout decision, buffer scan, secret compare, result.
// ----------------------------------------------------------------------------
module kcc_controller
    import kcc_pkg::*;
#(
    parameter int KEY_BUFFER_DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam int CW = $clog2(KEY_BUFFER_DEPTH + 2);
    localparam int MW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] LAST_SCAN = CW'(KEY_BUFFER_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVAL,
        ST_CMP,
        ST_CMP_END,
        ST_FINISH
    } t_state;

    t_state   r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_ans_sel r_ans_sel, n_ans_sel;

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ans_sel = r_ans_sel;
        o_cmd     = '0;
        o_cmd.ans_sel = r_ans_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_cnt = '0;
                case (i_stat.op)
                    OP_CHECK_SECRET: begin
                        if (i_stat.expired || i_stat.too_long) begin
                            n_ans_sel = ANS_ZERO;
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = ST_SCAN;
                        end
                    end
                    OP_CHECK_STARTED: begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end
                    default: begin
                        n_ans_sel = ANS_ZERO;
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SCAN) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_cnt = '0;
                if (i_stat.op == OP_CHECK_STARTED) begin
                    n_ans_sel = ANS_FOUND;
                    n_state = ST_FINISH;
                end else if (!i_stat.found) begin
                    n_ans_sel = ANS_ZERO;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.cmp_start = 1'b1;
                    n_ans_sel = ANS_SECRET;
                    if (i_stat.secret_length == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                o_cmd.issue = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (MW'(r_cnt) == MW'(i_stat.secret_length) - MW'(1)) begin
                    n_state = ST_CMP_END;
                end
            end
            ST_CMP_END: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ans_sel <= ANS_ZERO;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ans_sel <= n_ans_sel;
        end
    end

endmodule

FILE: src/kcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker datapath
// Configuration, key buffer memory, timeout test, scan and compare logic.
// ----------------------------------------------------------------------------
module kcc_datapath
    import kcc_pkg::*;
#(
    parameter int KEY_BUFFER_DEPTH = 16,
    parameter int KEY_BITS         = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [1:0]            i_operation,
    input  logic [3:0]            i_key,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_answer,
    output logic                  o_timed_out
);

    localparam int AW = $clog2(KEY_BUFFER_DEPTH);
    localparam int SW = ((AW > 4) ? AW : 4) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_BUFFER_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_W   = SW'(KEY_BUFFER_DEPTH);
    localparam logic [SW-1:0] PRE_W     = SW'(PREAMBLE_LEN);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    logic [CFG_DATA_W-1:0] r_secret;
    logic [3:0]            r_len;
    logic [31:0]           r_timeout;
    logic [3:0]            r_stop;
    logic [3:0]            r_empty;

    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [31:0]           r_now;

    logic [KEY_BITS-1:0]   r_mem [KEY_BUFFER_DEPTH];
    logic [KEY_BUFFER_DEPTH-1:0] r_valid, n_valid;
    logic [KEY_BITS-1:0]   r_clear_code;
    logic [AW-1:0]         r_widx;
    logic [31:0]           r_last;

    logic [AW-1:0]         r_addr;
    logic                  r_mode;
    logic                  r_rd_pend;
    logic                  r_rd_mode;
    logic [AW-1:0]         r_rd_addr;
    logic [KEY_BITS-1:0]   r_rd_data;
    logic                  r_rd_vbit;
    logic [KEY_BITS-1:0]   r_rd_want;
    logic [CFG_DATA_W-1:0] r_secret_sh;
    logic [1:0]            r_run;
    logic                  r_found;
    logic [AW-1:0]         r_end;
    logic                  r_match;
    logic                  r_tmo;

    logic                  r_out_valid;
    logic                  r_answer;
    logic                  r_timed_out;

    logic [31:0]           w_elapsed;
    logic                  w_expired;
    logic                  w_clear;
    logic                  w_add;
    logic [AW-1:0]         w_wr_addr;
    logic [KEY_BITS-1:0]   w_rd_key;
    logic                  w_stop_hit;
    logic [SW-1:0]         w_sum;
    logic [SW-1:0]         w_sum_wrap;
    logic                  w_idx_ok;
    logic                  w_too_long;

    assign w_elapsed = r_now - r_last;
    assign w_expired = (w_elapsed >= r_timeout);
    assign w_clear   = i_cmd.decide && ((r_op == OP_RESET) ||
                       (w_expired && ((r_op == OP_ADD_KEY) || (r_op == OP_CHECK_SECRET))));
    assign w_add     = i_cmd.decide && (r_op == OP_ADD_KEY);
    assign w_wr_addr = w_clear ? '0 : r_widx;

    assign w_rd_key   = r_rd_vbit ? r_rd_data : r_clear_code;
    assign w_stop_hit = (w_rd_key == r_stop[KEY_BITS-1:0]);

    assign w_sum      = SW'(r_end) + SW'(r_len);
    assign w_sum_wrap = (w_sum >= DEPTH_W) ? w_sum - DEPTH_W : w_sum;
    assign w_idx_ok   = (w_sum_wrap[AW-1:0] == r_widx);
    assign w_too_long = (SW'(r_len) + PRE_W) > DEPTH_W;

    always_comb begin
        n_valid = r_valid;
        if (w_clear) begin
            n_valid = '0;
        end
        if (w_add) begin
            n_valid[w_wr_addr] = 1'b1;
        end
    end

    always_comb begin
        o_stat.op            = r_op;
        o_stat.expired       = w_expired;
        o_stat.too_long      = w_too_long;
        o_stat.found         = r_found;
        o_stat.secret_length = r_len;
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_timed_out = r_timed_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret     <= '0;
            r_len        <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_stop       <= STOP_RESET;
            r_empty      <= '0;
            r_valid      <= '0;
            r_clear_code <= '0;
            r_widx       <= '0;
            r_last       <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SECRET_KEYS:    r_secret  <= i_cfg_data;
                    CFG_SECRET_LENGTH:  r_len     <= i_cfg_data[3:0];
                    CFG_TIMEOUT_MS:     r_timeout <= i_cfg_data[31:0];
                    CFG_STOP_KEY_CODE:  r_stop    <= i_cfg_data[3:0];
                    CFG_EMPTY_KEY_CODE: r_empty   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            r_valid <= n_valid;
            if (w_clear) begin
                r_clear_code <= r_empty[KEY_BITS-1:0];
            end
            if (w_add) begin
                r_widx <= wrap_inc(w_wr_addr);
            end else if (w_clear) begin
                r_widx <= '0;
            end
            if (w_clear || w_add) begin
                r_last <= r_now;
            end
            r_rd_pend <= i_cmd.issue;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_operation);
            r_key <= i_key[KEY_BITS-1:0];
            r_now <= i_now_ms;
        end
        if (w_add) begin
            r_mem[w_wr_addr] <= r_key;
        end
        if (i_cmd.decide) begin
            r_tmo <= w_expired && ((r_op == OP_ADD_KEY) || (r_op == OP_CHECK_SECRET));
        end
        if (i_cmd.scan_start) begin
            r_addr  <= '0;
            r_mode  <= 1'b0;
            r_run   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.cmp_start) begin
            r_addr      <= r_end;
            r_mode      <= 1'b1;
            r_secret_sh <= r_secret;
            r_match     <= 1'b1;
        end
        if (i_cmd.issue) begin
            r_rd_data   <= r_mem[r_addr];
            r_rd_vbit   <= r_valid[r_addr];
            r_rd_addr   <= r_addr;
            r_rd_mode   <= r_mode;
            r_rd_want   <= r_secret_sh[KEY_BITS-1:0];
            r_secret_sh <= r_secret_sh >> KEY_BITS;
            r_addr      <= wrap_inc(r_addr);
        end
        if (r_rd_pend) begin
            if (!r_rd_mode) begin
                if (w_stop_hit) begin
                    if (r_run == 2'd2) begin
                        r_found <= 1'b1;
                        r_end   <= wrap_inc(r_rd_addr);
                    end else begin
                        r_run <= r_run + 2'd1;
                    end
                end else begin
                    r_run <= '0;
                end
            end else if (w_rd_key != r_rd_want) begin
                r_match <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            r_timed_out <= r_tmo;
            case (i_cmd.ans_sel)
                ANS_FOUND:  r_answer <= r_found;
                ANS_SECRET: r_answer <= r_match && w_idx_ok;
                default:    r_answer <= 1'b0;
            endcase
        end
    end

endmodule

FILE: src/kcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker port checks
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module kcc_checker
    import kcc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_operation,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_answer,
    input logic       i_out_timed_out
);

    logic [1:0] r_pend;
    logic [1:0] r_last_op;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Counts items taken whose result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_last_op <= OP_ADD_KEY;
        end else begin
            if (w_in_acc && !w_out_acc) begin
                r_pend <= r_pend + 2'd1;
            end else if (!w_in_acc && w_out_acc && (r_pend != 2'd0)) begin
                r_pend <= r_pend - 2'd1;
            end
            if (w_in_acc) begin
                r_last_op <= i_in_operation;
            end
        end
    end

    // A result only appears for an item that has been taken.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (r_pend != 2'd0))
        else $error("result appeared without an accepted item");

    // Items are worked one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("ready stayed high after an item was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_answer)
        && $stable(i_out_timed_out))
        else $error("stalled result changed");

    // Add key and reset never answer 1; reset and check started never time out.
    a_op_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
        (!((r_last_op == OP_ADD_KEY) || (r_last_op == OP_RESET)) || !i_out_answer) &&
        (!((r_last_op == OP_RESET) || (r_last_op == OP_CHECK_STARTED))
         || !i_out_timed_out))
        else $error("result fields do not fit the operation");

endmodule

bind keypad_code_checker kcc_checker u_kcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_in_operation  (i_item.operation),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_answer    (o_result.answer),
    .i_out_timed_out (o_result.timed_out)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code checker testbench
// Streams key presses, resets and checks through the item channel. A model of
// the key buffer predicts every answer. Results are compared in order, and in
// some register settings both handshake sides stall at random. The run steps
// through several register settings, their extremes among them.
// ----------------------------------------------------------------------------
module tb;
    import kcc_pkg::*;

    localparam int KEY_DEPTH = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        t_op         op;
        logic [3:0]  key;
        logic [31:0] now_ms;
    } key_item_t;

    typedef struct packed {
        logic answer;
        logic timed_out;
    } code_result_t;

    typedef struct packed {
        key_item_t    item;
        code_result_t res;
    } awaited_t;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    kcc_item_if   item_ch ();
    kcc_result_if result_ch ();

    keypad_code_checker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    // Model of the block's configuration and key buffer.
    logic [63:0] secret_r;
    logic [3:0]  secret_len_r;
    logic [31:0] timeout_r;
    logic [3:0]  stop_r;
    logic [3:0]  empty_r;
    logic [3:0]  key_buf [KEY_DEPTH];
    logic [3:0]  wr_idx;
    logic [31:0] last_key_ms;

    key_item_t   key_presses [$];
    awaited_t    awaited_answers [$];
    logic [31:0] stim_ms;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        item_taken;
    int          stall_cycles;
    int          fails;
    int          n_items;
    int          n_results;
    int          n_answers;
    int          n_timeouts;
    int          n_settings;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_keys(logic [31:0] now);
        for (int i = 0; i < KEY_DEPTH; i++) begin
            key_buf[i] = empty_r;
        end
        wr_idx = '0;
        last_key_ms = now;
    endfunction

    // Returns {found, position just past the latest run of three stop keys}.
    function automatic logic [4:0] latest_preamble();
        logic       found;
        logic [3:0] pos_end;
        logic [3:0] p0;
        logic [3:0] p1;
        logic [3:0] p2;
        found = 1'b0;
        pos_end = '0;
        for (int s = 0; s < KEY_DEPTH; s++) begin
            p0 = s[3:0];
            p1 = p0 + 4'd1;
            p2 = p0 + 4'd2;
            if (key_buf[p0] == stop_r && key_buf[p1] == stop_r && key_buf[p2] == stop_r) begin
                found = 1'b1;
                pos_end = p0 + 4'd3;
            end
        end
        return {found, pos_end};
    endfunction

    function automatic logic secret_matches();
        logic [4:0] pre;
        logic [3:0] pos;
        if (int'(secret_len_r) + PREAMBLE_LEN > KEY_DEPTH) begin
            return 1'b0;
        end
        pre = latest_preamble();
        if (!pre[4]) begin
            return 1'b0;
        end
        for (int i = 0; i < int'(secret_len_r); i++) begin
            pos = pre[3:0] + i[3:0];
            if (key_buf[pos] != secret_r[i*4 +: 4]) begin
                return 1'b0;
            end
        end
        return wr_idx == pre[3:0] + secret_len_r;
    endfunction

    function automatic code_result_t predict_code(key_item_t it);
        code_result_t r;
        logic [31:0]  gap;
        logic [4:0]   pre;
        r = '0;
        gap = it.now_ms - last_key_ms;
        case (it.op)
            OP_ADD_KEY: begin
                if (gap >= timeout_r) begin
                    clear_keys(it.now_ms);
                    r.timed_out = 1'b1;
                end
                key_buf[wr_idx] = it.key;
                wr_idx = wr_idx + 4'd1;
                last_key_ms = it.now_ms;
            end
            OP_RESET: begin
                clear_keys(it.now_ms);
            end
            OP_CHECK_SECRET: begin
                if (gap >= timeout_r) begin
                    clear_keys(it.now_ms);
                    r.timed_out = 1'b1;
                end else begin
                    r.answer = secret_matches();
                end
            end
            default: begin
                pre = latest_preamble();
                r.answer = pre[4];
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_gap();
        int          r;
        logic [31:0] cap;
        r = $urandom_range(99);
        cap = (timeout_r >> 4) > 32'd500 ? 32'd500 : (timeout_r >> 4);
        if (r < 4) begin
            return timeout_r;
        end else if (r < 8) begin
            return timeout_r - 32'd1;
        end else if (r < 11) begin
            return $urandom;
        end
        return $urandom_range(0, cap);
    endfunction

    task automatic push_at(t_op op, logic [3:0] key, logic [31:0] now);
        key_item_t it;
        it.op = op;
        it.key = key;
        it.now_ms = now;
        stim_ms = now;
        key_presses.push_back(it);
    endtask

    task automatic add_item(t_op op, logic [3:0] key);
        push_at(op, key, stim_ms + pick_gap());
    endtask

    // A reset or leftover keys, a preamble, the secret and one or more checks,
    // with occasional faults.
    task automatic enter_code_attempt();
        int r;
        int lead;
        int stops;
        int bad;
        r = $urandom_range(99);
        if (r < 40) begin
            add_item(OP_RESET, 4'($urandom_range(15)));
        end
        lead = $urandom_range(0, 4);
        for (int i = 0; i < lead; i++) begin
            if ($urandom_range(99) < 40) begin
                add_item(OP_ADD_KEY, stop_r);
            end else begin
                add_item(OP_ADD_KEY, 4'($urandom_range(15)));
            end
        end
        r = $urandom_range(99);
        stops = (r < 10) ? 2 : (r < 20) ? 4 : 3;
        for (int i = 0; i < stops; i++) begin
            add_item(OP_ADD_KEY, stop_r);
        end
        bad = ($urandom_range(99) < 8) ? $urandom_range(0, 15) : -1;
        for (int i = 0; i < int'(secret_len_r); i++) begin
            if (i == bad) begin
                add_item(OP_ADD_KEY, 4'($urandom_range(15)));
            end else begin
                add_item(OP_ADD_KEY, secret_r[i*4 +: 4]);
            end
        end
        if ($urandom_range(99) < 10) begin
            add_item(OP_ADD_KEY, 4'($urandom_range(15)));
        end
        add_item(OP_CHECK_SECRET, 4'($urandom_range(15)));
        if ($urandom_range(99) < 50) begin
            add_item(OP_CHECK_STARTED, 4'($urandom_range(15)));
        end
        if ($urandom_range(99) < 15) begin
            add_item(OP_CHECK_SECRET, 4'($urandom_range(15)));
        end
    endtask

    task automatic wait_drained();
        while (key_presses.size() != 0 || item_ch.valid || awaited_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        case (addr)
            CFG_SECRET_KEYS:    secret_r = data;
            CFG_SECRET_LENGTH:  secret_len_r = data[3:0];
            CFG_TIMEOUT_MS:     timeout_r = data[31:0];
            CFG_STOP_KEY_CODE:  stop_r = data[3:0];
            CFG_EMPTY_KEY_CODE: empty_r = data[3:0];
            default: ;
        endcase
    endtask

    task automatic start_setting(logic [63:0] secret, logic [3:0] len, logic [31:0] tmo,
                                 logic [3:0] stop, logic [3:0] empty, int mode);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_SECRET_KEYS, secret);
        write_reg(CFG_SECRET_LENGTH, 64'(len));
        write_reg(CFG_TIMEOUT_MS, 64'(tmo));
        write_reg(CFG_STOP_KEY_CODE, 64'(stop));
        write_reg(CFG_EMPTY_KEY_CODE, 64'(empty));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 67 : 0;
        rx_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 26 : 0;
        n_settings++;
    endtask

    task automatic fill_random(int budget);
        while (key_presses.size() < budget) begin
            if ($urandom_range(99) < 70) begin
                enter_code_attempt();
            end else begin
                add_item(t_op'($urandom_range(3)), 4'($urandom_range(15)));
            end
        end
    endtask

    // Item driver: a held item stays until it is taken.
    always @(negedge i_clk) begin
        key_item_t nx;
        if (i_rst_n) begin
            if (!item_ch.valid || item_taken) begin
                if (key_presses.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nx = key_presses.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.operation <= nx.op;
                    item_ch.key <= nx.key;
                    item_ch.now_ms <= nx.now_ms;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic         took_item;
        logic         took_res;
        code_result_t got;
        awaited_t     want;
        key_item_t    it;
        took_item = i_rst_n && item_ch.valid && item_ch.ready;
        took_res = i_rst_n && result_ch.valid && result_ch.ready;
        item_taken <= took_item;
        if (took_res) begin
            got.answer = result_ch.answer;
            got.timed_out = result_ch.timed_out;
            n_results++;
            if (awaited_answers.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("%t: unexpected result answer=%b timed_out=%b",
                             $realtime, got.answer, got.timed_out);
                end
            end else begin
                want = awaited_answers.pop_front();
                if (got.answer === 1'b1) n_answers++;
                if (got.timed_out === 1'b1) n_timeouts++;
                if (got !== want.res) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%t: %s key=%h now=%h: expected answer=%b timed_out=%b, got answer=%b timed_out=%b",
                                 $realtime, want.item.op.name(), want.item.key,
                                 want.item.now_ms, want.res.answer, want.res.timed_out,
                                 got.answer, got.timed_out);
                    end
                end
            end
        end
        if (took_item) begin
            it.op = t_op'(item_ch.operation);
            it.key = item_ch.key;
            it.now_ms = item_ch.now_ms;
            awaited_answers.push_back({it, predict_code(it)});
            n_items++;
        end
        if (took_item || took_res || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.key = '0;
        item_ch.now_ms = '0;
        result_ch.ready = 1'b0;
        item_taken = 1'b0;
        stall_cycles = 0;
        fails = 0;
        n_items = 0;
        n_results = 0;
        n_answers = 0;
        n_timeouts = 0;
        n_settings = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stim_ms = '0;
        secret_r = '0;
        secret_len_r = '0;
        timeout_r = TIMEOUT_RESET;
        stop_r = STOP_RESET;
        empty_r = '0;
        clear_keys('0);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        start_setting(64'h0000_0000_0000_F0A5, 4'd4, 32'd1000, 4'd1, 4'd0, 0);
        push_at(OP_CHECK_STARTED, 4'h0, 32'd0);
        push_at(OP_CHECK_SECRET, 4'hF, 32'd5);
        push_at(OP_ADD_KEY, 4'h1, 32'd10);
        push_at(OP_ADD_KEY, 4'h1, 32'd11);
        push_at(OP_ADD_KEY, 4'h1, 32'd12);
        push_at(OP_ADD_KEY, 4'h5, 32'd13);
        push_at(OP_ADD_KEY, 4'hA, 32'd14);
        push_at(OP_ADD_KEY, 4'h0, 32'd15);
        push_at(OP_ADD_KEY, 4'hF, 32'd16);
        push_at(OP_CHECK_SECRET, 4'h0, 32'd17);
        push_at(OP_CHECK_STARTED, 4'h0, 32'd18);
        push_at(OP_ADD_KEY, 4'h3, 32'd19);
        push_at(OP_CHECK_SECRET, 4'h0, 32'd20);
        push_at(OP_CHECK_SECRET, 4'h0, 32'd1019);
        push_at(OP_CHECK_STARTED, 4'h0, 32'd1019);
        push_at(OP_ADD_KEY, 4'hF, 32'd2019);
        push_at(OP_RESET, 4'h0, 32'hFFFF_FFFF);
        push_at(OP_ADD_KEY, 4'h1, 32'd3);
        push_at(OP_ADD_KEY, 4'h1, 32'd4);
        push_at(OP_ADD_KEY, 4'h1, 32'd5);
        push_at(OP_ADD_KEY, 4'h5, 32'd6);
        push_at(OP_ADD_KEY, 4'hA, 32'd7);
        push_at(OP_ADD_KEY, 4'h0, 32'd8);
        push_at(OP_ADD_KEY, 4'hF, 32'd9);
        push_at(OP_CHECK_SECRET, 4'h0, 32'd10);
        fill_random(125);

        start_setting({$urandom, $urandom}, 4'd13, 32'hFFFF_FFFF, 4'd15, 4'd0, 0);
        fill_random(120);
        start_setting(64'd0, 4'd0, 32'd0, 4'd0, 4'd15, 0);
        fill_random(60);
        start_setting({64{1'b1}}, 4'd7, 32'd300, 4'd7, 4'd7, 1);
        fill_random(130);
        start_setting({$urandom, $urandom}, 4'd15, 32'd5000, 4'd3, 4'd9, 1);
        fill_random(60);
        start_setting({$urandom, $urandom}, 4'd14, 32'd5000, 4'd9, 4'd3, 1);
        fill_random(50);
        start_setting({$urandom, $urandom}, 4'($urandom_range(1, 12)), 32'd20000,
                      4'($urandom_range(15)), 4'($urandom_range(15)), 2);
        fill_random(140);
        start_setting({$urandom, $urandom}, 4'd1, 32'd1, 4'd14, 4'd1, 2);
        fill_random(100);
        start_setting({$urandom, $urandom}, 4'd12, TIMEOUT_RESET, STOP_RESET, 4'd0, 2);
        fill_random(170);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d items over %0d register settings with stalls on both sides.",
                 n_items, n_settings);
        $display("Checked %0d results: %0d with answer set, %0d cleared by timeout, %0d failures.",
                 n_results, n_answers, n_timeouts, fails);
        if (fails == 0 && awaited_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
src/kcc_pkg.sv
src/kcc_ifs.sv
src/kcc_controller.sv
src/kcc_datapath.sv
src/keypad_code_checker.sv
src/kcc_checker.sv
tb/sv/tb.sv
